// ===== design/pmbo_pkg.sv =====
package pmbo_pkg;

    // Coordinate and datapath widths
    localparam int CW     = 16;
    localparam int ACC_W  = 64;
    localparam int PW_W   = 12;
    localparam int ML_W   = 8;
    localparam int LQ_W   = 22;
    localparam int CFG_W  = 12;
    localparam int CNT_W  = 7;

    localparam logic [PW_W-1:0] PATH_WIDTH_RST  = PW_W'(640);
    localparam logic [ML_W-1:0] MITER_LIMIT_RST = ML_W'(32);

    localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] C_MIN = -ACC_W'(32768);

    // Configuration register indexes
    localparam logic CFG_PATH_WIDTH  = 1'b0;
    localparam logic CFG_MITER_LIMIT = 1'b1;

    // Joint kinds
    localparam logic [1:0] KIND_END   = 2'd0;
    localparam logic [1:0] KIND_BEVEL = 2'd1;
    localparam logic [1:0] KIND_MITER = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] left_x;
        logic signed [CW-1:0] left_y;
        logic signed [CW-1:0] right_x;
        logic signed [CW-1:0] right_y;
        logic [1:0]           joint_kind;
        logic                 degenerate;
        logic                 last_vertex;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    // Saturate a wide value to the coordinate range
    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [ACC_W-1:0] v);
        logic signed [CW-1:0] res;
        if (v > C_MAX) begin
            res = C_MAX[CW-1:0];
        end else if (v < C_MIN) begin
            res = C_MIN[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/pmbo_alu.sv =====
module pmbo_alu import pmbo_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_alu_cmd                i_cmd,
    input  logic signed [ACC_W-1:0] i_a,
    input  logic signed [ACC_W-1:0] i_b,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_result
);

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_x;
    logic [ACC_W-1:0] r_y;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [ACC_W-1:0] r_result;

    logic [ACC_W-1:0] a_mag;
    logic [ACC_W-1:0] b_mag;
    logic [ACC_W-1:0] div_num;
    logic [ACC_W-1:0] mul_acc;
    logic [ACC_W-1:0] rem_sh;
    logic             div_ge;
    logic [ACC_W-1:0] rem_n;
    logic [ACC_W-1:0] quo_n;
    logic [ACC_W-1:0] sq_t;
    logic             sq_ge;
    logic [ACC_W-1:0] sq_x;
    logic [ACC_W-1:0] sq_r;

    // Operand magnitudes and rounded dividend
    always_comb begin
        logic signed [ACC_W-1:0] nn;
        a_mag   = i_a[ACC_W-1] ? ACC_W'(-i_a) : ACC_W'(i_a);
        b_mag   = i_b[ACC_W-1] ? ACC_W'(-i_b) : ACC_W'(i_b);
        nn      = i_b[ACC_W-1] ? -i_a : i_a;
        div_num = (nn[ACC_W-1] ? ACC_W'(-nn) : ACC_W'(nn)) + (b_mag >> 1);
    end

    // One step of each operation
    always_comb begin
        mul_acc = r_y[0] ? r_acc + r_x : r_acc;
        rem_sh  = {r_acc[ACC_W-2:0], r_x[ACC_W-1]};
        div_ge  = rem_sh >= r_y;
        rem_n   = div_ge ? rem_sh - r_y : rem_sh;
        quo_n   = {r_x[ACC_W-2:0], div_ge};
        sq_t    = r_x + r_y;
        sq_ge   = r_acc >= sq_t;
        sq_x    = sq_ge ? r_acc - sq_t : r_acc;
        sq_r    = sq_ge ? (r_x >> 1) + r_y : (r_x >> 1);
    end

    // Load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                case (i_cmd.op)
                    OP_MUL: begin
                        r_acc <= '0;
                        r_x   <= a_mag;
                        r_y   <= b_mag;
                        r_neg <= i_a[ACC_W-1] ^ i_b[ACC_W-1];
                    end
                    OP_DIV: begin
                        r_acc <= '0;
                        r_x   <= div_num;
                        r_y   <= b_mag;
                        r_cnt <= CNT_W'(ACC_W);
                        r_neg <= i_a[ACC_W-1] ^ i_b[ACC_W-1];
                    end
                    default: begin
                        r_acc <= ACC_W'(i_a);
                        r_x   <= '0;
                        r_y   <= ACC_W'(1) << (ACC_W - 2);
                        r_neg <= 1'b0;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_MUL: begin
                        r_acc <= mul_acc;
                        r_x   <= r_x << 1;
                        r_y   <= r_y >> 1;
                        if (r_y[ACC_W-1:1] == '0) begin
                            r_busy   <= 1'b0;
                            r_done   <= 1'b1;
                            r_result <= r_neg ? -mul_acc : mul_acc;
                        end
                    end
                    OP_DIV: begin
                        r_acc <= rem_n;
                        r_x   <= quo_n;
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_busy   <= 1'b0;
                            r_done   <= 1'b1;
                            r_result <= r_neg ? -quo_n : quo_n;
                        end
                    end
                    default: begin
                        r_acc <= sq_x;
                        r_x   <= sq_r;
                        r_y   <= r_y >> 2;
                        if (r_y == ACC_W'(1)) begin
                            r_busy   <= 1'b0;
                            r_done   <= 1'b1;
                            r_result <= sq_r;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = signed'(r_result);

endmodule

// ===== design/polyline_miter_border_offset_unit.sv =====
// Polyline border offsetter with miter and bevel joins.
// Input channel (i_in_valid / o_in_stall / i_in_data): one vertex per
// transaction, last_point closes the polyline. Output channel (o_out_valid /
// i_out_stall / o_out_data): left and right border points per vertex, in
// vertex order. An interior vertex is emitted when the vertex after it
// arrives; the final vertex adds its own end point, so one transaction in
// gives zero, one or two transactions out.
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 path width,
// index 1 miter limit; always ready, write only while the block is idle.
// Throughput: one vertex at a time. All arithmetic runs on one shared
// iterative unit that does one operation at a time: a multiply steps
// through the bits of its second operand (up to 22 bits), a division
// through the quotient bits and a square root through the result bits.
// o_in_stall is high while a vertex is being processed.
// A finished point sits in the output register; while it is full and
// i_out_stall is high the sequencer holds before loading the next point.
// Reset: path width 640, miter limit 2.0, no vertices seen, output empty.
module polyline_miter_border_offset_unit import pmbo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        ST_SQX, ST_SQY, ST_LEN, ST_OXM, ST_OXD, ST_OYM, ST_OYD,
        ST_PS, ST_DX, ST_DY, ST_ML, ST_BV, ST_C1, ST_C2,
        ST_N1, ST_N2, ST_QXM, ST_QXD, ST_QYM, ST_QYD
    } t_step;

    typedef enum logic [2:0] {
        E_SINGLE, E_END_FIRST, E_MID_DEG, E_BEVEL, E_PARALLEL, E_MITER, E_END_LAST
    } t_emit;

    t_state r_state;
    t_step  r_step;
    t_emit  r_sel;
    logic   r_seg;     // 0: incoming-to-new segment, 1: older segment

    logic [PW_W-1:0] r_path_width;
    logic [ML_W-1:0] r_miter_limit;
    logic [1:0]      r_seen;

    logic signed [CW-1:0] r_px, r_py, r_prior_x, r_prior_y, r_older_x, r_older_y;
    logic                 r_last;

    logic signed [ACC_W-1:0] r_t0, r_ps, r_cr, r_n, r_qx, r_qy;
    logic [LQ_W-1:0]         r_lq, r_lq1, r_lq2;
    logic [2*ML_W-1:0]       r_ml2;
    logic signed [CW-1:0]    r_o1x, r_o1y, r_o2x, r_o2y;
    logic                    r_deg2;

    logic      r_out_valid;
    t_out_item r_out;

    logic signed [CW:0]      d1x, d1y, d2x, d2y, sdx, sdy;
    logic signed [ACC_W-1:0] op_a, op_b, res;
    logic signed [ACC_W-1:0] wq;
    t_alu_op                 op;
    t_alu_cmd                cmd;
    logic                    done;
    logic signed [ACC_W-1:0] cr_n;

    // Segment deltas
    always_comb begin
        d1x = {r_prior_x[CW-1], r_prior_x} - {r_older_x[CW-1], r_older_x};
        d1y = {r_prior_y[CW-1], r_prior_y} - {r_older_y[CW-1], r_older_y};
        d2x = {r_px[CW-1], r_px} - {r_prior_x[CW-1], r_prior_x};
        d2y = {r_py[CW-1], r_py} - {r_prior_y[CW-1], r_prior_y};
        sdx = r_seg ? d1x : d2x;
        sdy = r_seg ? d1y : d2y;
        wq  = ACC_W'({r_path_width, 3'b000});
        cr_n = r_cr - res;
    end

    // Operand select for the current step
    always_comb begin
        op   = OP_MUL;
        op_a = '0;
        op_b = '0;
        unique case (r_step)
            ST_SQX: begin op_a = ACC_W'(sdx); op_b = ACC_W'(sdx); end
            ST_SQY: begin op_a = ACC_W'(sdy); op_b = ACC_W'(sdy); end
            ST_LEN: begin op = OP_SQRT; op_a = r_t0 <<< 8; end
            ST_OXM: begin op_a = -ACC_W'(sdy); op_b = wq; end
            ST_OXD: begin op = OP_DIV; op_a = r_t0; op_b = ACC_W'(r_lq); end
            ST_OYM: begin op_a = ACC_W'(sdx); op_b = wq; end
            ST_OYD: begin op = OP_DIV; op_a = r_t0; op_b = ACC_W'(r_lq); end
            ST_PS:  begin op_a = ACC_W'(r_lq1); op_b = ACC_W'(r_lq2); end
            ST_DX:  begin op_a = ACC_W'(d1x); op_b = ACC_W'(d2x); end
            ST_DY:  begin op_a = ACC_W'(d1y); op_b = ACC_W'(d2y); end
            ST_ML:  begin op_a = ACC_W'(r_miter_limit); op_b = ACC_W'(r_miter_limit); end
            ST_BV:  begin op_a = r_ps + (r_t0 <<< 8); op_b = ACC_W'(r_ml2); end
            ST_C1:  begin op_a = ACC_W'(d1x); op_b = ACC_W'(d2y); end
            ST_C2:  begin op_a = ACC_W'(d1y); op_b = ACC_W'(d2x); end
            ST_N1:  begin op_a = ACC_W'(r_o2x) - ACC_W'(r_o1x); op_b = ACC_W'(d2y); end
            ST_N2:  begin op_a = ACC_W'(r_o2y) - ACC_W'(r_o1y); op_b = ACC_W'(d2x); end
            ST_QXM: begin op_a = r_n; op_b = ACC_W'(d1x); end
            ST_QXD: begin op = OP_DIV; op_a = r_t0; op_b = r_cr; end
            ST_QYM: begin op_a = r_n; op_b = ACC_W'(d1y); end
            ST_QYD: begin op = OP_DIV; op_a = r_t0; op_b = r_cr; end
            default: begin op = OP_MUL; end
        endcase
        cmd.start = (r_state == S_RUN);
        cmd.op    = op;
    end

    pmbo_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_done   (done),
        .o_result (res)
    );

    // Build the border point for the selected result
    t_out_item               emit_item;
    always_comb begin
        logic signed [CW-1:0]    vx, vy, ox, oy;
        logic signed [ACC_W-1:0] qx, qy;
        logic [1:0]              kind;
        logic                    deg, lst;
        vx = r_prior_x; vy = r_prior_y;
        ox = r_o1x; oy = r_o1y;
        qx = '0; qy = '0;
        kind = KIND_BEVEL; deg = 1'b0; lst = 1'b0;
        unique case (r_sel)
            E_SINGLE: begin
                vx = r_px; vy = r_py; ox = '0; oy = '0;
                kind = KIND_END; deg = 1'b1; lst = 1'b1;
            end
            E_END_FIRST: begin
                ox = r_o2x; oy = r_o2y; kind = KIND_END; deg = r_deg2;
            end
            E_MID_DEG: begin
                ox = '0; oy = '0; deg = 1'b1;
            end
            E_BEVEL: begin
                kind = KIND_BEVEL;
            end
            E_PARALLEL: begin
                kind = KIND_MITER;
            end
            E_MITER: begin
                kind = KIND_MITER; qx = r_qx; qy = r_qy;
            end
            E_END_LAST: begin
                vx = r_px; vy = r_py; ox = r_o2x; oy = r_o2y;
                kind = KIND_END; deg = r_deg2; lst = 1'b1;
            end
            default: begin
                kind = KIND_END;
            end
        endcase
        emit_item.left_x      = clamp_coord(ACC_W'(vx) + ACC_W'(ox) + qx);
        emit_item.left_y      = clamp_coord(ACC_W'(vy) + ACC_W'(oy) + qy);
        emit_item.right_x     = clamp_coord(ACC_W'(vx) - ACC_W'(ox) - qx);
        emit_item.right_y     = clamp_coord(ACC_W'(vy) - ACC_W'(oy) - qy);
        emit_item.joint_kind  = kind;
        emit_item.degenerate  = deg;
        emit_item.last_vertex = lst;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_width  <= PATH_WIDTH_RST;
            r_miter_limit <= MITER_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATH_WIDTH:  r_path_width  <= i_cfg_data;
                CFG_MITER_LIMIT: r_miter_limit <= i_cfg_data[ML_W-1:0];
                default:         r_path_width  <= r_path_width;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_SQX;
            r_sel       <= E_SINGLE;
            r_seg       <= 1'b0;
            r_seen      <= 2'd0;
            r_out_valid <= 1'b0;
            r_prior_x   <= '0;
            r_prior_y   <= '0;
            r_older_x   <= '0;
            r_older_y   <= '0;
        end else begin
            // Drop a transaction the receiver took
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px   <= i_in_data.point_x;
                        r_py   <= i_in_data.point_y;
                        r_last <= i_in_data.last_point;
                        if (r_seen == 2'd0) begin
                            if (i_in_data.last_point) begin
                                r_sel   <= E_SINGLE;
                                r_state <= S_EMIT;
                            end else begin
                                r_prior_x <= i_in_data.point_x;
                                r_prior_y <= i_in_data.point_y;
                                r_seen    <= 2'd1;
                            end
                        end else begin
                            r_seg   <= 1'b0;
                            r_step  <= ST_SQX;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (done) begin
                        r_state <= S_RUN;
                        case (r_step)
                            ST_SQX: begin r_t0 <= res; r_step <= ST_SQY; end
                            ST_SQY: begin r_t0 <= r_t0 + res; r_step <= ST_LEN; end
                            ST_LEN: begin
                                r_lq <= res[LQ_W-1:0];
                                if (r_seg) r_lq1 <= res[LQ_W-1:0];
                                else       r_lq2 <= res[LQ_W-1:0];
                                if (res == '0) begin
                                    if (r_seg) begin
                                        r_o1x <= '0; r_o1y <= '0;
                                    end else begin
                                        r_deg2 <= 1'b1; r_o2x <= '0; r_o2y <= '0;
                                    end
                                    // Skip the offset math: finish the segment now
                                    if (!r_seg && r_seen == 2'd2) begin
                                        r_seg  <= 1'b1;
                                        r_step <= ST_SQX;
                                    end else if (r_seen == 2'd2) begin
                                        r_sel   <= E_MID_DEG;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_sel   <= E_END_FIRST;
                                        r_state <= S_EMIT;
                                    end
                                end else begin
                                    if (!r_seg) r_deg2 <= 1'b0;
                                    r_step <= ST_OXM;
                                end
                            end
                            ST_OXM: begin r_t0 <= res; r_step <= ST_OXD; end
                            ST_OXD: begin
                                if (r_seg) r_o1x <= res[CW-1:0];
                                else       r_o2x <= res[CW-1:0];
                                r_step <= ST_OYM;
                            end
                            ST_OYM: begin r_t0 <= res; r_step <= ST_OYD; end
                            ST_OYD: begin
                                if (r_seg) r_o1y <= res[CW-1:0];
                                else       r_o2y <= res[CW-1:0];
                                if (!r_seg && r_seen == 2'd2) begin
                                    r_seg  <= 1'b1;
                                    r_step <= ST_SQX;
                                end else if (r_seen == 2'd2) begin
                                    if (r_deg2 || !r_seg) begin
                                        r_sel   <= E_MID_DEG;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_step <= ST_PS;
                                    end
                                end else begin
                                    r_sel   <= E_END_FIRST;
                                    r_state <= S_EMIT;
                                end
                            end
                            ST_PS: begin r_ps <= res; r_step <= ST_DX; end
                            ST_DX: begin r_t0 <= res; r_step <= ST_DY; end
                            ST_DY: begin r_t0 <= r_t0 + res; r_step <= ST_ML; end
                            ST_ML: begin r_ml2 <= res[2*ML_W-1:0]; r_step <= ST_BV; end
                            ST_BV: begin
                                if (res < (r_ps <<< 9)) begin
                                    r_sel   <= E_BEVEL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_step <= ST_C1;
                                end
                            end
                            ST_C1: begin r_cr <= res; r_step <= ST_C2; end
                            ST_C2: begin
                                r_cr <= cr_n;
                                if (cr_n == '0) begin
                                    r_sel   <= E_PARALLEL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_step <= ST_N1;
                                end
                            end
                            ST_N1:  begin r_n <= res; r_step <= ST_N2; end
                            ST_N2:  begin r_n <= r_n - res; r_step <= ST_QXM; end
                            ST_QXM: begin r_t0 <= res; r_step <= ST_QXD; end
                            ST_QXD: begin r_qx <= res; r_step <= ST_QYM; end
                            ST_QYM: begin r_t0 <= res; r_step <= ST_QYD; end
                            ST_QYD: begin
                                r_qy    <= res;
                                r_sel   <= E_MITER;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    // Load the output register once it is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= emit_item;
                        r_out_valid <= 1'b1;
                        if (r_last && r_sel != E_END_LAST && r_sel != E_SINGLE) begin
                            r_sel <= E_END_LAST;
                        end else begin
                            r_state <= S_IDLE;
                            if (r_last) begin
                                r_seen <= 2'd0;
                            end else begin
                                r_older_x <= r_prior_x;
                                r_older_y <= r_prior_y;
                                r_prior_x <= r_px;
                                r_prior_y <= r_py;
                                r_seen    <= 2'd2;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== dv/polyline_miter_border_offset_unit_tb.sv =====
module polyline_miter_border_offset_unit_tb import pmbo_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEP_MAX   = 12;
    localparam int  SETTLE     = 1200;
    localparam longint LIMIT   = 30_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = CFG_PATH_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    polyline_miter_border_offset_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow configuration and vertex history
    longint   width_q4 = 640;
    longint   limit_q4 = 32;
    longint   older_x = 0, older_y = 0, prior_x = 0, prior_y = 0;
    int       seen = 0;

    t_in_item  vertex_q[$];
    t_out_item border_q[$];
    int        errors = 0;
    longint    cycles = 0;

    // Floor square root
    function automatic longint isqrt(longint x);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Divide, rounding half away from zero
    function automatic longint round_div(longint n, longint d);
        longint mag;
        bit neg;
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        neg = n < 0;
        mag = neg ? -n : n;
        mag = (mag + d / 2) / d;
        return neg ? -mag : mag;
    endfunction

    function automatic longint seg_len(longint dx, longint dy);
        return isqrt((dx * dx + dy * dy) << 8);
    endfunction

    // Perpendicular half-width offset; returns 0 for a zero-length segment
    function automatic bit seg_offset(longint dx, longint dy, output longint ox,
                                      output longint oy);
        longint lq;
        lq = seg_len(dx, dy);
        ox = 0;
        oy = 0;
        if (lq == 0) return 1'b0;
        ox = round_div(-dy * width_q4 * 8, lq);
        oy = round_div(dx * width_q4 * 8, lq);
        return 1'b1;
    endfunction

    function automatic logic signed [CW-1:0] sat(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[CW-1:0];
    endfunction

    function automatic t_out_item border(longint lx, longint ly, longint rx, longint ry,
                                         logic [1:0] kind, bit deg, bit last);
        t_out_item r;
        r.left_x      = sat(lx);
        r.left_y      = sat(ly);
        r.right_x     = sat(rx);
        r.right_y     = sat(ry);
        r.joint_kind  = kind;
        r.degenerate  = deg;
        r.last_vertex = last;
        return r;
    endfunction

    function automatic t_out_item end_border(longint vx, longint vy, longint dx, longint dy,
                                             bit last);
        longint ox, oy;
        bit ok;
        ok = seg_offset(dx, dy, ox, oy);
        return border(vx + ox, vy + oy, vx - ox, vy - oy, KIND_END, !ok, last);
    endfunction

    function automatic t_out_item join_border(longint ax, longint ay, longint vx, longint vy,
                                              longint bx, longint by);
        longint d1x, d1y, d2x, d2y, o1x, o1y, o2x, o2y, ps, ds, cr, n;
        bit ok1, ok2;
        d1x = vx - ax;
        d1y = vy - ay;
        d2x = bx - vx;
        d2y = by - vy;
        ok1 = seg_offset(d1x, d1y, o1x, o1y);
        ok2 = seg_offset(d2x, d2y, o2x, o2y);
        if (!ok1 || !ok2) return border(vx, vy, vx, vy, KIND_BEVEL, 1'b1, 1'b0);
        ps = seg_len(d1x, d1y) * seg_len(d2x, d2y);
        ds = (d1x * d2x + d1y * d2y) * 256;
        if ((ps + ds) * (limit_q4 * limit_q4) < 512 * ps)
            return border(vx + o1x, vy + o1y, vx - o1x, vy - o1y, KIND_BEVEL, 1'b0, 1'b0);
        cr = d1x * d2y - d1y * d2x;
        if (cr == 0)
            return border(vx + o1x, vy + o1y, vx - o1x, vy - o1y, KIND_MITER, 1'b0, 1'b0);
        n = (o2x - o1x) * d2y - (o2y - o1y) * d2x;
        return border(vx + o1x + round_div(n * d1x, cr), vy + o1y + round_div(n * d1y, cr),
                      vx - o1x + round_div(-n * d1x, cr), vy - o1y + round_div(-n * d1y, cr),
                      KIND_MITER, 1'b0, 1'b0);
    endfunction

    // Append one expected border point
    task automatic expect_border(t_out_item b);
        border_q = {border_q, b};
    endtask

    // Advance the vertex history and queue the border points it yields
    task automatic accept_vertex(t_in_item v);
        longint px, py;
        px = longint'(v.point_x);
        py = longint'(v.point_y);
        if (seen == 0) begin
            if (v.last_point) begin
                expect_border(border(px, py, px, py, KIND_END, 1'b1, 1'b1));
            end else begin
                prior_x = px;
                prior_y = py;
                seen = 1;
            end
        end else begin
            if (seen == 1)
                expect_border(end_border(prior_x, prior_y, px - prior_x, py - prior_y,
                                         1'b0));
            else
                expect_border(join_border(older_x, older_y, prior_x, prior_y, px, py));
            if (v.last_point) begin
                expect_border(end_border(px, py, px - prior_x, py - prior_y, 1'b1));
                seen = 0;
            end else begin
                older_x = prior_x;
                older_y = prior_y;
                prior_x = px;
                prior_y = py;
                seen = 2;
            end
        end
    endtask

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    endtask

    // Input driver: random gap before each transaction, bursts without gaps
    int in_gap = 0;
    bit in_burst = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                accept_vertex(i_in_data);
                void'(vertex_q.pop_front());
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (vertex_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= vertex_q[0];
                    if ($urandom_range(0, 40) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, STEP_MAX);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each transaction, stall at random
    int out_wait = 0;
    bit out_burst = 1'b0;
    always @(posedge i_clk) begin
        t_out_item want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (border_q.size() == 0) begin
                    report("unexpected transaction", 0, 0);
                end else begin
                    want = border_q.pop_front();
                    if (o_out_data.left_x != want.left_x)
                        report("left_x", o_out_data.left_x, want.left_x);
                    if (o_out_data.left_y != want.left_y)
                        report("left_y", o_out_data.left_y, want.left_y);
                    if (o_out_data.right_x != want.right_x)
                        report("right_x", o_out_data.right_x, want.right_x);
                    if (o_out_data.right_y != want.right_y)
                        report("right_y", o_out_data.right_y, want.right_y);
                    if (o_out_data.joint_kind != want.joint_kind)
                        report("joint_kind", o_out_data.joint_kind, want.joint_kind);
                    if (o_out_data.degenerate != want.degenerate)
                        report("degenerate", o_out_data.degenerate, want.degenerate);
                    if (o_out_data.last_vertex != want.last_vertex)
                        report("last_vertex", o_out_data.last_vertex, want.last_vertex);
                end
                if ($urandom_range(0, 30) == 0) out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, STEP_MAX);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PATH_WIDTH) width_q4 = 64'(val);
        else limit_q4 = 64'(val[ML_W-1:0]);
    endtask

    task automatic add_vertex(longint x, longint y, bit last);
        t_in_item v;
        v.point_x    = sat(x);
        v.point_y    = sat(y);
        v.last_point = last;
        vertex_q = {vertex_q, v};
    endtask

    // Random polyline: short, medium or full-range steps or random points, sometimes repeats
    task automatic add_polyline();
        int n, mode, step;
        longint x, y;
        n = $urandom_range(0, 7) == 0 ? 1 : $urandom_range(2, 8);
        mode = $urandom_range(0, 3);
        step = mode == 0 ? 32767 : (mode == 1 ? 64 : 4000);
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if (mode == 3) begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end else if ($urandom_range(0, 11) != 0) begin
                    x = x + $urandom_range(0, 2 * step) - step;
                    y = y + $urandom_range(0, 2 * step) - step;
                end
            end
            add_vertex(x, y, i == n - 1);
        end
    endtask

    task automatic drain();
        while (vertex_q.size() > 0 || i_in_valid || border_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single point, extremes, straight line, U-turn, right angle, zero segments
        add_vertex(-32768, 32767, 1);
        add_vertex(-32768, -32768, 0);
        add_vertex(32767, 32767, 0);
        add_vertex(-32768, 32767, 1);
        add_vertex(0, 0, 0);
        add_vertex(160, 0, 0);
        add_vertex(320, 0, 1);
        add_vertex(0, 0, 0);
        add_vertex(400, 0, 0);
        add_vertex(0, 16, 1);
        add_vertex(100, 100, 0);
        add_vertex(500, 100, 0);
        add_vertex(500, -300, 1);
        add_vertex(7, 7, 0);
        add_vertex(7, 7, 0);
        add_vertex(50, 90, 0);
        add_vertex(50, 90, 1);
        add_vertex(32767, -32768, 0);
        add_vertex(32700, -32700, 0);
        add_vertex(-32768, 32767, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_PATH_WIDTH, 12'd0);
                    write_reg(CFG_MITER_LIMIT, 12'd16);
                end
                1: begin
                    write_reg(CFG_PATH_WIDTH, 12'd4095);
                    write_reg(CFG_MITER_LIMIT, 12'd255);
                end
                2: begin
                    write_reg(CFG_PATH_WIDTH, 12'd1);
                    write_reg(CFG_MITER_LIMIT, 12'd0);
                end
                3: begin
                    write_reg(CFG_PATH_WIDTH, 12'd640);
                    write_reg(CFG_MITER_LIMIT, 12'hF10);
                end
                4: begin
                    write_reg(CFG_PATH_WIDTH, CFG_W'($urandom_range(0, 4095)));
                    write_reg(CFG_MITER_LIMIT, CFG_W'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_PATH_WIDTH, 12'd2048);
                    write_reg(CFG_MITER_LIMIT, 12'd32);
                end
            endcase
            for (int k = 0; k < 72; k++) add_polyline();
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/pmbo_pkg.sv
design/pmbo_alu.sv
design/polyline_miter_border_offset_unit.sv
dv/polyline_miter_border_offset_unit_tb.sv
